>>> rtl/core/direct_address_map_table_core_macros.svh
// ----------------------------------------------------------------------------
// Direct address map table assertion macros
// Shared concurrent assertion forms for the direct address map table core.
// ----------------------------------------------------------------------------
`ifndef DIRECT_ADDRESS_MAP_TABLE_CORE_MACROS_SVH
`define DIRECT_ADDRESS_MAP_TABLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define DAMT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define DAMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/damt_pkg.sv
// ----------------------------------------------------------------------------
// Direct address map table package
// Request and status codes and the result beat record of the table core.
// ----------------------------------------------------------------------------
package damt_pkg;

  localparam int unsigned KEY_OUT_W   = 6;
  localparam int unsigned VALUE_OUT_W = 32;
  localparam int unsigned COUNT_OUT_W = 7;

  typedef enum logic [1:0] {
    REQ_PUT  = 2'd0,
    REQ_GET  = 2'd1,
    REQ_FIND = 2'd2,
    REQ_LIST = 2'd3
  } req_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  typedef struct packed {
    logic [1:0]             status;
    logic [KEY_OUT_W-1:0]   key;
    logic [VALUE_OUT_W-1:0] value;
    logic [COUNT_OUT_W-1:0] count;
    logic                   last;
  } out_beat_t;

  function automatic out_beat_t make_beat(logic [1:0] st, logic [KEY_OUT_W-1:0] k,
                                          logic [VALUE_OUT_W-1:0] v,
                                          logic [COUNT_OUT_W-1:0] c, logic l);
    out_beat_t b;
    b.status = st;
    b.key    = k;
    b.value  = v;
    b.count  = c;
    b.last   = l;
    return b;
  endfunction

endpackage

>>> rtl/core/damt_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module damt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/damt_occ.sv
// ----------------------------------------------------------------------------
// Direct address map table occupancy tracker
// Holds one occupied bit per slot and the count of occupied slots.
// ----------------------------------------------------------------------------
module damt_occ #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       set_en,
  input  logic [$clog2(DEPTH)-1:0]   set_idx,
  output logic [DEPTH-1:0]           occ,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DEPTH-1:0] occ_r;
  logic [CW-1:0]    count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= '0;
      count_r <= '0;
    end else if (set_en && !occ_r[set_idx]) begin
      occ_r[set_idx] <= 1'b1;
      count_r        <= count_r + CW'(1);
    end
  end

  assign occ   = occ_r;
  assign count = count_r;

endmodule

>>> rtl/core/direct_address_map_table_core.sv
// ----------------------------------------------------------------------------
// Direct address map table core
// A put, or a get with a key out of range, finishes in the cycle it is
// accepted and its result appears in the next cycle. A get reads the value
// memory in the accepting cycle and forms its result in S_GET. Find and list
// sweep every slot through the single read port of the value memory, one slot
// per cycle; each compare runs in the cycle after its read address, and a
// closing S_FLUSH step issues the final beat. Busy stays high until the last
// beat of a request has been issued. Each result beat is shown on the out_
// ports for exactly one cycle under out_valid and the receiver cannot stall
// it.
// ----------------------------------------------------------------------------
`include "direct_address_map_table_core_macros.svh"

module direct_address_map_table_core #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_key,
  input  logic [31:0] in_value_in,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [5:0]  out_key_out,
  output logic [31:0] out_value_out,
  output logic [6:0]  out_elem_count,
  output logic        out_last
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int unsigned KW = damt_pkg::KEY_OUT_W;
  localparam int unsigned OW = damt_pkg::VALUE_OUT_W;
  localparam int unsigned NW = damt_pkg::COUNT_OUT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GET,
    S_SCAN,
    S_FLUSH
  } state_t;

  state_t                  state_r, state_nxt;
  damt_pkg::req_t          req_r, req_nxt;
  logic [AW-1:0]           kidx_r, kidx_nxt;
  logic [KW-1:0]           key6_r, key6_nxt;
  logic [VALUE_WIDTH-1:0]  want_r, want_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic                    rd_v_r, rd_v_nxt;
  logic [AW-1:0]           rd_idx_r, rd_idx_nxt;
  logic                    pend_v_r, pend_v_nxt;
  logic [KW-1:0]           pend_key_r, pend_key_nxt;
  logic [OW-1:0]           pend_val_r, pend_val_nxt;
  logic                    out_valid_r, out_valid_nxt;
  damt_pkg::out_beat_t     out_r, out_nxt;

  logic                    accept;
  logic                    in_range;
  logic [AW-1:0]           in_idx;
  logic [VALUE_WIDTH-1:0]  in_val;
  logic                    ram_we;
  logic [AW-1:0]           ram_raddr;
  logic [VALUE_WIDTH-1:0]  ram_rdata;
  logic [DEPTH-1:0]        occ;
  logic [CW-1:0]           count;
  logic                    scan_hit;
  logic [NW-1:0]           count_out;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign in_range  = (in_key < 16'(DEPTH));
  assign in_idx    = in_key[AW-1:0];
  assign in_val    = VALUE_WIDTH'(in_value_in[MW-1:0]);
  assign ram_we    = accept && in_range && (damt_pkg::req_t'(in_req_type) == damt_pkg::REQ_PUT);
  assign ram_raddr = (state_r == S_IDLE) ? in_idx : idx_r[AW-1:0];
  assign count_out = NW'(count);
  assign scan_hit  = occ[rd_idx_r] && ((req_r == damt_pkg::REQ_LIST) || (ram_rdata == want_r));

  damt_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_idx),
    .wdata (in_val),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  damt_occ #(
    .DEPTH (DEPTH)
  ) u_occ (
    .clk     (clk),
    .rst_n   (rst_n),
    .set_en  (ram_we),
    .set_idx (in_idx),
    .occ     (occ),
    .count   (count)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    kidx_nxt      = kidx_r;
    key6_nxt      = key6_r;
    want_nxt      = want_r;
    idx_nxt       = idx_r;
    rd_v_nxt      = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    pend_v_nxt    = pend_v_r;
    pend_key_nxt  = pend_key_r;
    pend_val_nxt  = pend_val_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt  = damt_pkg::req_t'(in_req_type);
          kidx_nxt = in_idx;
          key6_nxt = in_key[KW-1:0];
          want_nxt = in_val;
          unique case (damt_pkg::req_t'(in_req_type))
            damt_pkg::REQ_PUT, damt_pkg::REQ_GET: begin
              if (!in_range) begin
                out_valid_nxt = 1'b1;
                out_nxt = damt_pkg::make_beat(damt_pkg::ST_RANGE, in_key[KW-1:0], '0,
                                              count_out, 1'b1);
              end else if (damt_pkg::req_t'(in_req_type) == damt_pkg::REQ_PUT) begin
                out_valid_nxt = 1'b1;
                out_nxt = damt_pkg::make_beat(damt_pkg::ST_OK, in_key[KW-1:0],
                                              OW'(in_val[MW-1:0]),
                                              occ[in_idx] ? count_out
                                                          : NW'(count + CW'(1)),
                                              1'b1);
              end else begin
                state_nxt = S_GET;
              end
            end
            damt_pkg::REQ_FIND, damt_pkg::REQ_LIST: begin
              idx_nxt    = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = S_SCAN;
            end
          endcase
        end
      end
      S_GET: begin
        out_valid_nxt = 1'b1;
        if (occ[kidx_r]) begin
          out_nxt = damt_pkg::make_beat(damt_pkg::ST_OK, key6_r, OW'(ram_rdata[MW-1:0]),
                                        count_out, 1'b1);
        end else begin
          out_nxt = damt_pkg::make_beat(damt_pkg::ST_NOT_FOUND, key6_r, '0,
                                        count_out, 1'b1);
        end
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (idx_r != CW'(DEPTH)) begin
          rd_v_nxt   = 1'b1;
          rd_idx_nxt = idx_r[AW-1:0];
          idx_nxt    = idx_r + CW'(1);
        end
        if (rd_v_r) begin
          if (scan_hit) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_nxt = damt_pkg::make_beat(damt_pkg::ST_OK, pend_key_r, pend_val_r,
                                            count_out, 1'b0);
            end
            pend_v_nxt   = 1'b1;
            pend_key_nxt = KW'(rd_idx_r);
            pend_val_nxt = OW'(ram_rdata[MW-1:0]);
          end
          if (rd_idx_r == AW'(DEPTH - 1)) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        out_valid_nxt = 1'b1;
        if (pend_v_r) begin
          out_nxt = damt_pkg::make_beat(damt_pkg::ST_OK, pend_key_r, pend_val_r,
                                        count_out, 1'b1);
        end else begin
          out_nxt = damt_pkg::make_beat(damt_pkg::ST_NOT_FOUND, '0, '0, count_out, 1'b1);
        end
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_v_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_v_r      <= rd_v_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    kidx_r     <= kidx_nxt;
    key6_r     <= key6_nxt;
    want_r     <= want_nxt;
    idx_r      <= idx_nxt;
    rd_idx_r   <= rd_idx_nxt;
    pend_key_r <= pend_key_nxt;
    pend_val_r <= pend_val_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_r.status;
  assign out_key_out    = out_r.key;
  assign out_value_out  = out_r.value;
  assign out_elem_count = out_r.count;
  assign out_last       = out_r.last;

  // A put always answers with a single final beat in the following cycle.
  `DAMT_ASSERT_NEXT(a_put_beat,
                    accept && (damt_pkg::req_t'(in_req_type) == damt_pkg::REQ_PUT),
                    out_valid && out_last, "put without final beat")
  // The closing step of a scan issues the final beat and frees the block.
  `DAMT_ASSERT_NEXT(a_flush_done, state_r == S_FLUSH,
                    out_valid && out_last && !busy, "scan did not close")
  // A key out of range is reported once and ends its request.
  `DAMT_ASSERT_IMPL(a_range_last, out_valid && (out_status == damt_pkg::ST_RANGE),
                    out_last, "range beat not final")
  // The occupied count can never pass the number of slots.
  `DAMT_ASSERT_IMPL(a_count_max, 1'b1, count <= CW'(DEPTH), "occupied count overflow")

endmodule
